FILE: rtl/d2py_pkg.sv
package d2py_pkg;

    // Fixed field widths.
    localparam int IN_W  = 32;
    localparam int OUT_W = 25;

    // Defaults for the top-level parameters.
    localparam int DEF_CORDIC_ITERATIONS = 16;
    localparam int DEF_FRAC_BITS         = 16;

    // Depth of each queue, a power of two.
    localparam int QUEUE_DEPTH = 2;

    // The integer square root of a 64-bit value resolves one result bit per stage.
    localparam int SQRT_STAGES = 32;

    // Word handed from the front part to the back part.
    typedef struct packed {
        logic signed [IN_W-1:0] x;
        logic signed [IN_W-1:0] y;
        logic signed [IN_W-1:0] z;
        logic [IN_W-1:0]        ax;
        logic [IN_W-1:0]        ay;
        logic                   zero;
    } front_word_t;

    // Word of one finished result.
    typedef struct packed {
        logic [OUT_W-1:0] pitch;
        logic [OUT_W-1:0] yaw;
    } result_word_t;

    // Elementary CORDIC angle of stage idx in signed Q32 degrees, worked out
    // at elaboration from a truncated arctangent series.
    function automatic logic [63:0] angle_q32(input int idx);
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] rad;
        logic        neg;
        int          k;
        begin
            if (idx == 0) begin
                return 64'd45 << 32;
            end
            sum = 64'd0;
            neg = 1'b0;
            for (k = 1; k * idx <= 60; k += 2) begin
                term = (64'd1 << (60 - k * idx)) / 64'(k);
                sum  = neg ? sum - term : sum + term;
                neg  = !neg;
            end
            rad = sum >> 30;
            return (rad * 64'd3845054675) >> 24;
        end
    endfunction

endpackage

FILE: rtl/d2py_fifo.sv
module d2py_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [PW:0]      wr_ptr_reg;
    logic [PW:0]      rd_ptr_reg;
    logic [PW:0]      wr_ptr_next;
    logic [PW:0]      rd_ptr_next;
    logic             do_push;
    logic             do_pop;

    // Pointer compare: equal means empty, equal except the wrap bit means full.
    assign empty   = (wr_ptr_reg == rd_ptr_reg);
    assign full    = (wr_ptr_reg[PW] != rd_ptr_reg[PW]) &&
                     (wr_ptr_reg[PW-1:0] == rd_ptr_reg[PW-1:0]);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg[PW-1:0]];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Storage holds no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg[PW-1:0]] <= wdata;
        end
    end

endmodule

FILE: rtl/d2py_front.sv
module d2py_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [d2py_pkg::IN_W-1:0] dir_x,
    input  logic signed [d2py_pkg::IN_W-1:0] dir_y,
    input  logic signed [d2py_pkg::IN_W-1:0] dir_z,
    output logic                          word_valid,
    input  logic                          word_full,
    output d2py_pkg::front_word_t         word
);
    import d2py_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    front_word_t word_reg;
    front_word_t word_next;
    logic        take;
    logic        hand_off;

    assign hand_off   = valid_reg && !word_full;
    assign full       = valid_reg && word_full;
    assign take       = push && !full;
    assign word_valid = valid_reg;
    assign word       = word_reg;

    // Classify the vector and take the magnitudes of x and y.
    always_comb
    begin
        word_next.x    = dir_x;
        word_next.y    = dir_y;
        word_next.z    = dir_z;
        word_next.ax   = dir_x[IN_W-1] ? (~dir_x + 1'b1) : dir_x;
        word_next.ay   = dir_y[IN_W-1] ? (~dir_y + 1'b1) : dir_y;
        word_next.zero = (dir_x == '0) && (dir_y == '0);
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (hand_off)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg <= word_next;
        end
    end

endmodule

FILE: rtl/d2py_back.sv
module d2py_back #(
    parameter int CORDIC_ITERATIONS = d2py_pkg::DEF_CORDIC_ITERATIONS,
    parameter int FRAC_BITS         = d2py_pkg::DEF_FRAC_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_pop,
    input  d2py_pkg::front_word_t  in_word,
    output logic                   out_valid,
    input  logic                   out_full,
    output d2py_pkg::result_word_t out_word
);
    import d2py_pkg::*;

    localparam int ITER = CORDIC_ITERATIONS;
    localparam int SQ   = SQRT_STAGES;
    localparam int CW   = 52;
    localparam int AW   = 42;
    localparam logic signed [AW-1:0] ACC_90  = AW'(64'd90 << 32);
    localparam logic signed [AW-1:0] ACC_360 = AW'(64'd360 << 32);

    typedef struct packed {
        logic signed [IN_W-1:0] x;
        logic signed [IN_W-1:0] y;
        logic signed [IN_W-1:0] z;
        logic                   zero;
    } carry_t;

    typedef struct packed {
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic signed [AW-1:0] acc;
    } vec_t;

    logic   adv;

    logic   v_a0_reg;
    logic [63:0] sqx_reg;
    logic [63:0] sqy_reg;
    carry_t car_a0_reg;

    logic   v_s_reg   [0:SQ];
    logic [63:0] rem_reg [0:SQ];
    logic [63:0] res_reg [0:SQ];
    carry_t car_s_reg [0:SQ];

    logic   v_c_reg    [0:ITER];
    logic   zero_c_reg [0:ITER];
    logic   zpos_c_reg [0:ITER];
    logic signed [CW-1:0] ya_reg   [0:ITER];
    logic signed [CW-1:0] yb_reg   [0:ITER];
    logic signed [AW-1:0] yacc_reg [0:ITER];
    logic signed [CW-1:0] pa_reg   [0:ITER];
    logic signed [CW-1:0] pb_reg   [0:ITER];
    logic signed [AW-1:0] pacc_reg [0:ITER];

    logic         v_o_reg;
    result_word_t out_reg;
    result_word_t out_next;
    vec_t         yaw_pre;
    vec_t         pitch_pre;
    logic signed [CW-1:0] r_ext;

    // Quarter-turn pre-rotation into the right half plane.
    function automatic vec_t prerot(input logic signed [CW-1:0] a,
                                    input logic signed [CW-1:0] b);
        vec_t v;
        begin
            v.a   = a;
            v.b   = b;
            v.acc = '0;
            if (a < 0)
            begin
                if (b >= 0)
                begin
                    v.a   = b;
                    v.b   = -a;
                    v.acc = ACC_90;
                end
                else
                begin
                    v.a   = -b;
                    v.b   = a;
                    v.acc = -ACC_90;
                end
            end
            return v;
        end
    endfunction

    // Wrap into one turn and round half up to the output fraction.
    function automatic logic [OUT_W-1:0] to_out(input logic signed [AW-1:0] acc);
        logic signed [AW-1:0] w;
        logic [63:0]          u;
        logic [63:0]          r;
        begin
            w = (acc < 0) ? acc + ACC_360 : acc;
            u = {{(64-AW){1'b0}}, w};
            r = (u + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
            if (r >= (64'd360 << FRAC_BITS))
            begin
                r = r - (64'd360 << FRAC_BITS);
            end
            return r[OUT_W-1:0];
        end
    endfunction

    // The whole pipeline moves together unless a result is stuck at the end.
    assign adv       = !(v_o_reg && out_full);
    assign in_pop    = adv && in_valid;
    assign out_valid = v_o_reg;
    assign out_word  = out_reg;

    // Valid bits of the first stage of each section and of the output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a0_reg   <= 1'b0;
            v_s_reg[0] <= 1'b0;
            v_c_reg[0] <= 1'b0;
            v_o_reg    <= 1'b0;
        end
        else if (adv)
        begin
            v_a0_reg   <= in_valid;
            v_s_reg[0] <= v_a0_reg;
            v_c_reg[0] <= v_s_reg[SQ];
            v_o_reg    <= v_c_reg[ITER];
        end
    end

    // Squares of the magnitudes, then their sum into the root pipeline.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqx_reg         <= 64'(in_word.ax) * 64'(in_word.ax);
            sqy_reg         <= 64'(in_word.ay) * 64'(in_word.ay);
            car_a0_reg.x    <= in_word.x;
            car_a0_reg.y    <= in_word.y;
            car_a0_reg.z    <= in_word.z;
            car_a0_reg.zero <= in_word.zero;
            rem_reg[0]      <= sqx_reg + sqy_reg;
            res_reg[0]      <= '0;
            car_s_reg[0]    <= car_a0_reg;
        end
    end

    // Integer square root, one result bit per stage.
    for (genvar gj = 0; gj < SQ; gj++)
    begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * gj);
        logic [63:0] trial;

        assign trial = res_reg[gj] + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_s_reg[gj+1] <= 1'b0;
            end
            else if (adv)
            begin
                v_s_reg[gj+1] <= v_s_reg[gj];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                car_s_reg[gj+1] <= car_s_reg[gj];
                if (rem_reg[gj] >= trial)
                begin
                    rem_reg[gj+1] <= rem_reg[gj] - trial;
                    res_reg[gj+1] <= (res_reg[gj] >> 1) + BIT;
                end
                else
                begin
                    rem_reg[gj+1] <= rem_reg[gj];
                    res_reg[gj+1] <= res_reg[gj] >> 1;
                end
            end
        end
    end

    // Operands of both angle units, scaled by 2^16 and pre-rotated.
    always_comb
    begin
        r_ext     = CW'(res_reg[SQ][31:0]);
        yaw_pre   = prerot(CW'(car_s_reg[SQ].x) <<< 16, CW'(car_s_reg[SQ].y) <<< 16);
        pitch_pre = prerot(r_ext <<< 16, -(CW'(car_s_reg[SQ].z) <<< 16));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ya_reg[0]     <= yaw_pre.a;
            yb_reg[0]     <= yaw_pre.b;
            yacc_reg[0]   <= yaw_pre.acc;
            pa_reg[0]     <= pitch_pre.a;
            pb_reg[0]     <= pitch_pre.b;
            pacc_reg[0]   <= pitch_pre.acc;
            zero_c_reg[0] <= car_s_reg[SQ].zero;
            zpos_c_reg[0] <= (car_s_reg[SQ].z > 0);
        end
    end

    // CORDIC vectoring stages, yaw and pitch side by side.
    for (genvar gi = 0; gi < ITER; gi++)
    begin : g_cordic
        localparam logic signed [AW-1:0] ANG = AW'(angle_q32(gi));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_c_reg[gi+1] <= 1'b0;
            end
            else if (adv)
            begin
                v_c_reg[gi+1] <= v_c_reg[gi];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                zero_c_reg[gi+1] <= zero_c_reg[gi];
                zpos_c_reg[gi+1] <= zpos_c_reg[gi];
                if (yb_reg[gi] >= 0)
                begin
                    ya_reg[gi+1]   <= ya_reg[gi] + (yb_reg[gi] >>> gi);
                    yb_reg[gi+1]   <= yb_reg[gi] - (ya_reg[gi] >>> gi);
                    yacc_reg[gi+1] <= yacc_reg[gi] + ANG;
                end
                else
                begin
                    ya_reg[gi+1]   <= ya_reg[gi] - (yb_reg[gi] >>> gi);
                    yb_reg[gi+1]   <= yb_reg[gi] + (ya_reg[gi] >>> gi);
                    yacc_reg[gi+1] <= yacc_reg[gi] - ANG;
                end
                if (pb_reg[gi] >= 0)
                begin
                    pa_reg[gi+1]   <= pa_reg[gi] + (pb_reg[gi] >>> gi);
                    pb_reg[gi+1]   <= pb_reg[gi] - (pa_reg[gi] >>> gi);
                    pacc_reg[gi+1] <= pacc_reg[gi] + ANG;
                end
                else
                begin
                    pa_reg[gi+1]   <= pa_reg[gi] - (pb_reg[gi] >>> gi);
                    pb_reg[gi+1]   <= pb_reg[gi] + (pa_reg[gi] >>> gi);
                    pacc_reg[gi+1] <= pacc_reg[gi] - ANG;
                end
            end
        end
    end

    // Final wrap and rounding; a vector on the z axis takes fixed angles.
    always_comb
    begin
        logic [63:0] special;
        special = zpos_c_reg[ITER] ? (64'd270 << FRAC_BITS) : (64'd90 << FRAC_BITS);
        if (zero_c_reg[ITER])
        begin
            out_next.pitch = special[OUT_W-1:0];
            out_next.yaw   = '0;
        end
        else
        begin
            out_next.pitch = to_out(pacc_reg[ITER]);
            out_next.yaw   = to_out(yacc_reg[ITER]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

endmodule

FILE: rtl/direction_to_pitch_yaw_core.sv
// Turns a direction vector (signed Q15.16 x, y, z) into yaw = atan2(y, x) and
// pitch = atan2(-z, sqrt(x*x + y*y)), both in degrees as unsigned Q9.16 in
// [0, 360); a vector with x and y both zero gives yaw 0 and pitch 270 when z
// is positive, else 90. Both sides look like queues: push while full is low,
// pop while empty is low. One vector is taken every cycle while full is low, and
// each result passes through the 32-stage square root pipeline followed by one
// CORDIC stage per iteration, with yaw and pitch resolved side by side.
module direction_to_pitch_yaw_core #(
    parameter int CORDIC_ITERATIONS = d2py_pkg::DEF_CORDIC_ITERATIONS,
    parameter int FRAC_BITS         = d2py_pkg::DEF_FRAC_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic signed [d2py_pkg::IN_W-1:0]  dir_x,
    input  logic signed [d2py_pkg::IN_W-1:0]  dir_y,
    input  logic signed [d2py_pkg::IN_W-1:0]  dir_z,
    output logic                             empty,
    input  logic                             pop,
    output logic [d2py_pkg::OUT_W-1:0]       pitch_deg,
    output logic [d2py_pkg::OUT_W-1:0]       yaw_deg
);
    import d2py_pkg::*;

    logic         fw_valid;
    logic         mid_full;
    front_word_t  fw_word;
    logic         mid_empty;
    logic         mid_pop;
    front_word_t  mid_word;
    logic         res_valid;
    logic         res_full;
    result_word_t res_word;
    result_word_t out_word;

    // Front part: takes and classifies each word.
    d2py_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .dir_x      (dir_x),
        .dir_y      (dir_y),
        .dir_z      (dir_z),
        .word_valid (fw_valid),
        .word_full  (mid_full),
        .word       (fw_word)
    );

    // Short queue between the front and back parts.
    d2py_fifo #(
        .WIDTH ($bits(front_word_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fw_valid),
        .full  (mid_full),
        .wdata (fw_word),
        .pop   (mid_pop),
        .empty (mid_empty),
        .rdata (mid_word)
    );

    // Back part: square root and angle pipelines.
    d2py_back #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS),
        .FRAC_BITS         (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (!mid_empty),
        .in_pop    (mid_pop),
        .in_word   (mid_word),
        .out_valid (res_valid),
        .out_full  (res_full),
        .out_word  (res_word)
    );

    // Result queue toward the consumer.
    d2py_fifo #(
        .WIDTH ($bits(result_word_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_valid),
        .full  (res_full),
        .wdata (res_word),
        .pop   (pop),
        .empty (empty),
        .rdata (out_word)
    );

    assign pitch_deg = out_word.pitch;
    assign yaw_deg   = out_word.yaw;

endmodule

FILE: bench/direction_to_pitch_yaw_core_tb.sv
`timescale 1ns / 1ps

module direction_to_pitch_yaw_core_tb;

    import d2py_pkg::*;

    localparam int ITERS = DEF_CORDIC_ITERATIONS;
    localparam int FRAC  = DEF_FRAC_BITS;

    typedef struct {
        logic [OUT_W-1:0] pitch;
        logic [OUT_W-1:0] yaw;
    } angle_pair_t;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic signed [IN_W-1:0] dir_x;
    logic signed [IN_W-1:0] dir_y;
    logic signed [IN_W-1:0] dir_z;
    logic empty;
    logic pop;
    logic [OUT_W-1:0] pitch_deg;
    logic [OUT_W-1:0] yaw_deg;

    // Expected angle pairs, oldest first.
    angle_pair_t pending_angles[$];
    longint atan_deg_q32[32];
    int  error_count;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  recv_hold_cycles;

    direction_to_pitch_yaw_core i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .dir_x(dir_x),
        .dir_y(dir_y),
        .dir_z(dir_z),
        .empty(empty),
        .pop(pop),
        .pitch_deg(pitch_deg),
        .yaw_deg(yaw_deg)
    );

    // The clock runs with a 20 ns period.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Elementary angles in signed Q32 degrees from the arctangent series.
    function automatic void build_atan_table();
        longint unsigned sum;
        longint unsigned term;
        longint unsigned rad;
        bit neg;
        atan_deg_q32[0] = 64'sd45 <<< 32;
        for (int i = 1; i < 32; i++)
        begin
            sum = 0;
            neg = 1'b0;
            for (int k = 1; k * i <= 60; k += 2)
            begin
                term = (64'd1 << (60 - k * i)) / longint'(k);
                sum = neg ? sum - term : sum + term;
                neg = !neg;
            end
            rad = sum >> 30;
            atan_deg_q32[i] = longint'((rad * 64'd3845054675) >> 24);
        end
    endfunction

    // Floor of the square root, one result bit per step.
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned bit_val;
        root = 0;
        bit_val = 64'd1 << 62;
        while (bit_val > n)
            bit_val >>= 2;
        while (bit_val != 0)
        begin
            if (n >= root + bit_val)
            begin
                n = n - (root + bit_val);
                root = (root >> 1) + bit_val;
            end
            else
                root >>= 1;
            bit_val >>= 2;
        end
        return root;
    endfunction

    // Angle of the vector (a, b) in Q32 degrees by CORDIC vectoring.
    function automatic longint vector_angle(input longint a, input longint b);
        longint acc;
        longint t;
        longint da;
        longint db;
        acc = 0;
        if (a < 0)
        begin
            t = a;
            if (b >= 0)
            begin
                a = b;
                b = -t;
                acc = 64'sd90 <<< 32;
            end
            else
            begin
                a = -b;
                b = t;
                acc = -(64'sd90 <<< 32);
            end
        end
        for (int i = 0; i < ITERS && i < 32; i++)
        begin
            da = b >>> i;
            db = a >>> i;
            if (b >= 0)
            begin
                a += da;
                b -= db;
                acc += atan_deg_q32[i];
            end
            else
            begin
                a -= da;
                b += db;
                acc -= atan_deg_q32[i];
            end
        end
        return acc;
    endfunction

    // Wrap into one turn and round half up to the output fraction.
    function automatic logic [OUT_W-1:0] degrees_out(input longint acc);
        longint unsigned u;
        longint unsigned r;
        while (acc < 0)
            acc += 64'sd360 <<< 32;
        while (acc >= (64'sd360 <<< 32))
            acc -= 64'sd360 <<< 32;
        u = acc;
        r = (u + (64'd1 << (31 - FRAC))) >> (32 - FRAC);
        if (r >= (64'd360 << FRAC))
            r -= 64'd360 << FRAC;
        return r[OUT_W-1:0];
    endfunction

    function automatic angle_pair_t predict_angles(input logic signed [IN_W-1:0] x,
                                                   input logic signed [IN_W-1:0] y,
                                                   input logic signed [IN_W-1:0] z);
        angle_pair_t res;
        longint xs;
        longint ys;
        longint zs;
        longint unsigned ax;
        longint unsigned ay;
        longint rad_len;
        xs = x;
        ys = y;
        zs = z;
        if (xs == 0 && ys == 0)
        begin
            res.yaw = '0;
            res.pitch = (zs > 0) ? OUT_W'(270 << FRAC) : OUT_W'(90 << FRAC);
        end
        else
        begin
            ax = (xs < 0) ? -xs : xs;
            ay = (ys < 0) ? -ys : ys;
            rad_len = int_sqrt(ax * ax + ay * ay);
            res.yaw = degrees_out(vector_angle(xs * 65536, ys * 65536));
            res.pitch = degrees_out(vector_angle(rad_len * 65536, -zs * 65536));
        end
        return res;
    endfunction

    // Offer one vector, with a random gap first, and wait until it is taken.
    task automatic send_vector(input logic [IN_W-1:0] x, input logic [IN_W-1:0] y,
                               input logic [IN_W-1:0] z);
        angle_pair_t exp_pair;
        exp_pair = predict_angles(x, y, z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        push = 1'b1;
        dir_x = x;
        dir_y = y;
        dir_z = z;
        @(posedge clk);
        while (full)
            @(posedge clk);
        pending_angles.push_back(exp_pair);
        @(negedge clk);
    endtask

    // Random component, with magnitude spread over many scales.
    function automatic logic [IN_W-1:0] rand_component();
        logic [IN_W-1:0] v;
        v = $urandom;
        case ($urandom_range(3))
            0: return v;
            1: return $signed(v) >>> $urandom_range(31);
            2: return $signed(v) >>> $urandom_range(24, 31);
            default: return ($urandom_range(9) == 0) ? '0 : $signed(v) >>> 16;
        endcase
    endfunction

    // Receiver: pop at random, or hold off while a stall is pending.
    always @(negedge clk)
    begin
        if (!rst_n)
            pop = 1'b0;
        else if (recv_hold_cycles > 0)
        begin
            pop = 1'b0;
            recv_hold_cycles = recv_hold_cycles - 1;
        end
        else
            pop = ($urandom_range(99) < recv_idle_pct) ? 1'b0 : 1'b1;
    end

    // Each word taken from the block is checked against the oldest expectation.
    always @(posedge clk)
    begin
        angle_pair_t exp_pair;
        if (rst_n && pop && !empty)
        begin
            if (pending_angles.size() == 0)
            begin
                $display("%0t: unexpected word pitch=%0d yaw=%0d", $time, pitch_deg, yaw_deg);
                error_count++;
            end
            else
            begin
                exp_pair = pending_angles.pop_front();
                if (pitch_deg !== exp_pair.pitch)
                begin
                    $display("%0t: pitch_deg expected %0d actual %0d", $time,
                             exp_pair.pitch, pitch_deg);
                    error_count++;
                end
                if (yaw_deg !== exp_pair.yaw)
                begin
                    $display("%0t: yaw_deg expected %0d actual %0d", $time,
                             exp_pair.yaw, yaw_deg);
                    error_count++;
                end
            end
        end
    end

    // Axes, zero vectors and the extremes of every component.
    task automatic test_directed();
        logic [IN_W-1:0] mx;
        logic [IN_W-1:0] mn;
        mx = 32'h7fffffff;
        mn = 32'h80000000;
        send_vector(0, 0, 32'h00010000);
        send_vector(0, 0, 0);
        send_vector(0, 0, 32'hffff0000);
        send_vector(0, 0, mx);
        send_vector(0, 0, mn);
        send_vector(32'h00010000, 0, 0);
        send_vector(32'hffff0000, 0, 0);
        send_vector(0, 32'h00010000, 0);
        send_vector(0, 32'hffff0000, 0);
        send_vector(32'hffffffff, 0, 1);
        send_vector(32'hffffffff, 32'hffffffff, 32'hffffffff);
        send_vector(1, 1, 1);
        send_vector(mx, mx, mx);
        send_vector(mn, mn, mn);
        send_vector(mx, mn, mx);
        send_vector(mn, mx, mn);
        send_vector(mn, 0, mx);
        send_vector(0, mn, 0);
        send_vector(mx, 0, mn);
        send_vector(0, mx, 32'h00010000);
        send_vector(32'h00010000, 32'h00010000, 32'hfffe0000);
        send_vector(32'hffff0000, 32'h00010000, 32'h00010000);
    endtask

    task automatic test_random(input int count, input int snd_idle, input int rcv_idle);
        send_idle_pct = snd_idle;
        recv_idle_pct = rcv_idle;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(19) == 0)
                send_vector(0, 0, rand_component());
            else
                send_vector(rand_component(), rand_component(), rand_component());
        end
        push = 1'b0;
    endtask

    // Long receiver stall while vectors keep coming, so the block backs up.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(negedge clk);
        recv_hold_cycles = 300;
        for (int n = 0; n < 100; n++)
            send_vector(rand_component(), rand_component(), rand_component());
        push = 1'b0;
    endtask

    initial
    begin
        error_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold_cycles = 0;
        push = 1'b0;
        pop = 1'b0;
        dir_x = '0;
        dir_y = '0;
        dir_z = '0;
        build_atan_table();
        rst_n = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(175, 28, 64);
        test_random(175, 64, 28);
        test_random(180, 0, 0);
        test_backpressure();

        while (pending_angles.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #20000000;
        $display("Verification failed");
        $finish;
    end

endmodule
